// ===== rtl/brs_pkg.sv =====
// Package for the bracketed root search block: widths, status codes,
// configuration register indexes and reset values.
// No dependencies.
package brs_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int RES_WIDTH       = DATA_WIDTH + 1;
    localparam int PROD_WIDTH      = 2 * RES_WIDTH;
    localparam int CNT_WIDTH       = $clog2(PROD_WIDTH);
    localparam int ITER_WIDTH      = 6;
    localparam int TOL_WIDTH       = 16;
    localparam int STATUS_WIDTH    = 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [STATUS_WIDTH-1:0] STATUS_EVAL    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FOUND   = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_LIMIT   = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] STATUS_IGNORED = 2'd3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_METHOD    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ITER  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOLERANCE = 2'd2;

    localparam logic                  METHOD_RESET    = 1'b0;
    localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET  = 6'd60;
    localparam logic [TOL_WIDTH-1:0]  TOLERANCE_RESET = 16'd1;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_LEFT  = 4'b0010,
        PH_RIGHT = 4'b0100,
        PH_MID   = 4'b1000
    } phase_t;

    typedef enum logic [5:0] {
        ST_READY = 6'b000001,
        ST_EST   = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_SAT   = 6'b010000,
        ST_DONE  = 6'b100000
    } seq_state_t;

endpackage

// ===== rtl/bracketed_root_search.sv =====
// Top level of the bracketed root search block: handshake, search control and
// a shared add/subtract unit that runs the false position multiply and divide.
// Depends on brs_pkg.

// A start beat or a reply beat that needs no new estimate gives its result in
// the cycle after acceptance. A midpoint estimate passes through the estimate
// and done states. False position passes a setup state, 33 shift-add
// multiply steps and 66 restoring divide steps through the single shared adder,
// a saturation state and the done state. The block takes no input beat while
// an estimate is in progress; configuration writes are taken at any time.
module bracketed_root_search (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic [brs_pkg::DATA_WIDTH-1:0]       s_left_x,
    input  logic [brs_pkg::DATA_WIDTH-1:0]       s_right_x,
    input  logic [brs_pkg::DATA_WIDTH-1:0]       s_target,
    input  logic [brs_pkg::DATA_WIDTH-1:0]       s_func_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [brs_pkg::STATUS_WIDTH-1:0]     m_status,
    output logic [brs_pkg::DATA_WIDTH-1:0]       m_x_value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [brs_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [brs_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import brs_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int RW = RES_WIDTH;
    localparam int PW = PROD_WIDTH;

    logic                  method_reg, method_next;
    logic [ITER_WIDTH-1:0] max_iter_reg, max_iter_next;
    logic [TOL_WIDTH-1:0]  tol_reg, tol_next;

    seq_state_t            st_reg, st_next;
    phase_t                phase_reg, phase_next;
    logic                  smethod_reg, smethod_next;
    logic [ITER_WIDTH-1:0] iter_reg, iter_next;
    logic [DW-1:0]         low_reg, low_next;
    logic [DW-1:0]         high_reg, high_next;
    logic [RW-1:0]         low_res_reg, low_res_next;
    logic [RW-1:0]         high_res_reg, high_res_next;
    logic [DW-1:0]         probe_reg, probe_next;
    logic [DW-1:0]         wanted_reg, wanted_next;

    logic [PW-1:0]         prod_reg, prod_next;
    logic [RW-1:0]         mcand_reg, mcand_next;
    logic [RW-1:0]         divisor_reg, divisor_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic                  neg_reg, neg_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;

    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_WIDTH-1:0] m_status_reg, m_status_next;
    logic [DW-1:0]           m_x_reg, m_x_next;

    logic [RW:0]   alu_a, alu_b;
    logic          alu_sub;
    logic [RW+1:0] alu_sum;

    logic                  out_free, accept;
    logic [RW-1:0]         fm, dx_cur, mid_sum, dx_mag, lr_mag;
    logic [RW:0]           den, den_neg;
    logic [DW-1:0]         mid;
    logic                  tol_hit, same_sign, fm_zero;
    logic [ITER_WIDTH-1:0] iter_inc;
    logic [RW-1:0]         q_sat;
    logic [RW+1:0]         x_sum;
    logic [DW-1:0]         x_sat;
    logic                  out_load;
    logic [STATUS_WIDTH-1:0] out_status;
    logic [DW-1:0]         out_x;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (st_reg == ST_READY) && out_free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_x_value = m_x_reg;

    assign fm       = {s_func_value[DW-1], s_func_value} - {wanted_reg[DW-1], wanted_reg};
    assign fm_zero  = (fm == '0);
    assign dx_cur   = {high_reg[DW-1], high_reg} - {low_reg[DW-1], low_reg};
    assign tol_hit  = $signed(dx_cur) <= $signed({{(RW-TOL_WIDTH){1'b0}}, tol_reg});
    assign mid_sum  = {low_reg[DW-1], low_reg} + {high_reg[DW-1], high_reg};
    assign mid      = mid_sum[RW-1:1];
    assign same_sign = (!low_res_reg[RW-1] && (low_res_reg != '0) && !fm[RW-1] && !fm_zero)
                    || (low_res_reg[RW-1] && fm[RW-1]);
    assign iter_inc = iter_reg + 1'b1;

    assign dx_mag  = dx_cur[RW-1] ? (~dx_cur + 1'b1) : dx_cur;
    assign lr_mag  = low_res_reg[RW-1] ? (~low_res_reg + 1'b1) : low_res_reg;
    assign den     = {high_res_reg[RW-1], high_res_reg} - {low_res_reg[RW-1], low_res_reg};
    assign den_neg = ~den + 1'b1;

    assign q_sat = (prod_reg > {{(PW-RW){1'b0}}, 1'b1, {DW{1'b0}}})
                 ? {1'b1, {DW{1'b0}}} : prod_reg[RW-1:0];
    assign x_sum = neg_reg ? ({{2{low_reg[DW-1]}}, low_reg[DW-1], low_reg} + {2'b00, q_sat})
                           : ({{2{low_reg[DW-1]}}, low_reg[DW-1], low_reg} - {2'b00, q_sat});

    always_comb begin
        if (!x_sum[RW+1] && (|x_sum[RW:DW-1])) begin
            x_sat = {1'b0, {(DW-1){1'b1}}};
        end else if (x_sum[RW+1] && !(&x_sum[RW:DW-1])) begin
            x_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            x_sat = x_sum[DW-1:0];
        end
    end

    always_comb begin
        alu_sub = (st_reg == ST_DIV);
        if (st_reg == ST_DIV) begin
            alu_a = {rem_reg, prod_reg[PW-1]};
            alu_b = {1'b0, divisor_reg};
        end else begin
            alu_a = {1'b0, prod_reg[PW-1:RW]};
            alu_b = {1'b0, prod_reg[0] ? mcand_reg : {RW{1'b0}}};
        end
        alu_sum = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b}
                + {{(RW+1){1'b0}}, alu_sub};
    end

    always_comb begin
        method_next   = method_reg;
        max_iter_next = max_iter_reg;
        tol_next      = tol_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_METHOD:    method_next   = cfg_data[0];
                CFG_MAX_ITER:  max_iter_next = cfg_data[ITER_WIDTH-1:0];
                CFG_TOLERANCE: tol_next      = cfg_data[TOL_WIDTH-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        st_next       = st_reg;
        phase_next    = phase_reg;
        smethod_next  = smethod_reg;
        iter_next     = iter_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        low_res_next  = low_res_reg;
        high_res_next = high_res_reg;
        probe_next    = probe_reg;
        wanted_next   = wanted_reg;
        prod_next     = prod_reg;
        mcand_next    = mcand_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        out_load      = 1'b0;
        out_status    = STATUS_EVAL;
        out_x         = probe_reg;

        unique case (st_reg)
            ST_READY: begin
                if (accept) begin
                    if (!s_kind) begin
                        low_next     = s_left_x;
                        high_next    = s_right_x;
                        wanted_next  = s_target;
                        smethod_next = method_reg;
                        iter_next    = '0;
                        probe_next   = s_left_x;
                        phase_next   = PH_LEFT;
                        out_load     = 1'b1;
                        out_x        = s_left_x;
                    end else begin
                        unique case (phase_reg)
                            PH_LEFT: begin
                                low_res_next = fm;
                                if (smethod_reg) begin
                                    probe_next = high_reg;
                                    phase_next = PH_RIGHT;
                                    out_load   = 1'b1;
                                    out_x      = high_reg;
                                end else begin
                                    phase_next = PH_MID;
                                    st_next    = ST_EST;
                                end
                            end
                            PH_RIGHT: begin
                                high_res_next = fm;
                                phase_next    = PH_MID;
                                st_next       = ST_EST;
                            end
                            PH_MID: begin
                                iter_next = iter_inc;
                                if (fm_zero || tol_hit) begin
                                    phase_next = PH_IDLE;
                                    out_load   = 1'b1;
                                    out_status = STATUS_FOUND;
                                end else begin
                                    if (same_sign) begin
                                        low_next     = probe_reg;
                                        low_res_next = fm;
                                    end else begin
                                        high_next     = probe_reg;
                                        high_res_next = fm;
                                    end
                                    if (iter_inc >= max_iter_reg) begin
                                        phase_next = PH_IDLE;
                                        out_load   = 1'b1;
                                        out_status = STATUS_LIMIT;
                                    end else begin
                                        st_next = ST_EST;
                                    end
                                end
                            end
                            default: begin
                                out_load   = 1'b1;
                                out_status = STATUS_IGNORED;
                                out_x      = '0;
                            end
                        endcase
                    end
                end
            end
            ST_EST: begin
                if (!smethod_reg || (high_res_reg == low_res_reg)) begin
                    probe_next = mid;
                    st_next    = ST_DONE;
                end else begin
                    prod_next    = {{RW{1'b0}}, lr_mag};
                    mcand_next   = dx_mag;
                    divisor_next = den[RW] ? den_neg[RW-1:0] : den[RW-1:0];
                    neg_next     = dx_cur[RW-1] ^ low_res_reg[RW-1] ^ den[RW];
                    cnt_next     = CNT_WIDTH'(RW - 1);
                    st_next      = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next = {alu_sum[RW:0], prod_reg[RW-1:1]};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    rem_next = '0;
                    cnt_next = CNT_WIDTH'(PW - 1);
                    st_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = alu_sum[RW+1] ? alu_sum[RW-1:0] : alu_a[RW-1:0];
                prod_next = {prod_reg[PW-2:0], alu_sum[RW+1]};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    st_next = ST_SAT;
                end
            end
            ST_SAT: begin
                probe_next = x_sat;
                st_next    = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    st_next  = ST_READY;
                end
            end
            default: st_next = ST_READY;
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_x_next      = m_x_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_status_next = out_status;
            m_x_next      = out_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg   <= METHOD_RESET;
            max_iter_reg <= MAX_ITER_RESET;
            tol_reg      <= TOLERANCE_RESET;
            st_reg       <= ST_READY;
            phase_reg    <= PH_IDLE;
            smethod_reg  <= 1'b0;
            iter_reg     <= '0;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            method_reg   <= method_next;
            max_iter_reg <= max_iter_next;
            tol_reg      <= tol_next;
            st_reg       <= st_next;
            phase_reg    <= phase_next;
            smethod_reg  <= smethod_next;
            iter_reg     <= iter_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        low_reg      <= low_next;
        high_reg     <= high_next;
        low_res_reg  <= low_res_next;
        high_res_reg <= high_res_next;
        probe_reg    <= probe_next;
        wanted_reg   <= wanted_next;
        prod_reg     <= prod_next;
        mcand_reg    <= mcand_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        m_status_reg <= m_status_next;
        m_x_reg      <= m_x_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_READY) |-> !s_ready)
        else $error("Input beat offered while an estimate is in progress.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DONE && out_free) |=> (m_valid && m_status == STATUS_EVAL))
        else $error("Finished estimate did not reach the output register.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_IGNORED) |-> (m_x_value == '0))
        else $error("Ignored beat carries a nonzero point.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_MUL) |-> (cnt_reg <= CNT_WIDTH'(RW - 1)))
        else $error("Multiply step count out of range.");

endmodule

// ===== tb/root_search_checker.sv =====
// Checker for the bracketed root search block: watches the input, result and
// register write channels, predicts every result and compares it field by field.
// Depends on brs_pkg.
module root_search_checker import brs_pkg::*; #(
    parameter logic START_KIND = 1'b0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_kind,
    input  logic [DATA_WIDTH-1:0]      s_left_x,
    input  logic [DATA_WIDTH-1:0]      s_right_x,
    input  logic [DATA_WIDTH-1:0]      s_target,
    input  logic [DATA_WIDTH-1:0]      s_func_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [STATUS_WIDTH-1:0]    m_status,
    input  logic [DATA_WIDTH-1:0]      m_x_value,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                         failures,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint X_MAX     = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint X_MIN     = -X_MAX - 1;
    localparam longint QUOT_CAP  = longint'(1) << DATA_WIDTH;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic [DATA_WIDTH-1:0]   x;
    } answer_t;

    answer_t                answers_due[$];
    int                     mismatch_total = 0;

    logic                   use_secant;
    logic [ITER_WIDTH-1:0]  iter_limit;
    logic [TOL_WIDTH-1:0]   width_tol;

    phase_t                 search_phase;
    logic                   latched_secant;
    logic [ITER_WIDTH-1:0]  probes_done;
    longint                 lo_end, hi_end, lo_res, hi_res, probe, wanted;

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp(longint v);
        if (v > X_MAX) return X_MAX;
        if (v < X_MIN) return X_MIN;
        return v;
    endfunction

    // Midpoint, or the secant zero crossing when false position is latched and
    // the end residuals differ.
    function automatic longint next_probe();
        longint       dx, den, q;
        logic [131:0] quo;
        logic         neg;
        if (!latched_secant || hi_res == lo_res) return (lo_end + hi_end) >>> 1;
        dx  = hi_end - lo_end;
        den = hi_res - lo_res;
        quo = (132'(magnitude(dx)) * 132'(magnitude(lo_res))) / 132'(magnitude(den));
        q   = (quo > 132'(QUOT_CAP)) ? QUOT_CAP : longint'(quo[63:0]);
        neg = ((dx < 0) != (lo_res < 0)) != (den < 0);
        return clamp(neg ? lo_end + q : lo_end - q);
    endfunction

    task automatic advance_search(input logic kind,
                                  input logic [DATA_WIDTH-1:0] lx, rx, tg, fv,
                                  output answer_t ans);
        longint resid;
        ans.status = STATUS_IGNORED;
        if (kind == START_KIND) begin
            lo_end         = longint'($signed(lx));
            hi_end         = longint'($signed(rx));
            wanted         = longint'($signed(tg));
            latched_secant = use_secant;
            probes_done    = '0;
            probe          = lo_end;
            search_phase   = PH_LEFT;
            ans.status     = STATUS_EVAL;
        end else begin
            resid = longint'($signed(fv)) - wanted;
            case (search_phase)
                PH_LEFT: begin
                    lo_res = resid;
                    if (latched_secant) begin
                        probe        = hi_end;
                        search_phase = PH_RIGHT;
                    end else begin
                        probe        = next_probe();
                        search_phase = PH_MID;
                    end
                    ans.status = STATUS_EVAL;
                end
                PH_RIGHT: begin
                    hi_res       = resid;
                    probe        = next_probe();
                    search_phase = PH_MID;
                    ans.status   = STATUS_EVAL;
                end
                PH_MID: begin
                    probes_done = probes_done + 1'b1;
                    if (resid == 0 || hi_end - lo_end <= longint'(width_tol)) begin
                        search_phase = PH_IDLE;
                        ans.status   = STATUS_FOUND;
                    end else begin
                        if ((lo_res > 0 && resid > 0) || (lo_res < 0 && resid < 0)) begin
                            lo_end = probe;
                            lo_res = resid;
                        end else begin
                            hi_end = probe;
                            hi_res = resid;
                        end
                        if (probes_done >= iter_limit) begin
                            search_phase = PH_IDLE;
                            ans.status   = STATUS_LIMIT;
                        end else begin
                            probe      = next_probe();
                            ans.status = STATUS_EVAL;
                        end
                    end
                end
                default: ans.status = STATUS_IGNORED;
            endcase
        end
        ans.x = (ans.status == STATUS_IGNORED) ? '0 : probe[DATA_WIDTH-1:0];
    endtask

    always @(posedge aclk) begin : watch
        answer_t due;
        answer_t fresh;
        if (!aresetn) begin
            use_secant     = METHOD_RESET;
            iter_limit     = MAX_ITER_RESET;
            width_tol      = TOLERANCE_RESET;
            search_phase   = PH_IDLE;
            latched_secant = 1'b0;
            probes_done    = '0;
            lo_end         = 0;
            hi_end         = 0;
            lo_res         = 0;
            hi_res         = 0;
            probe          = 0;
            wanted         = 0;
            answers_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_METHOD:    use_secant = cfg_data[0];
                    CFG_MAX_ITER:  iter_limit = cfg_data[ITER_WIDTH-1:0];
                    CFG_TOLERANCE: width_tol  = cfg_data[TOL_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result beat with none expected, actual status %0d x %h",
                             $time, m_status, m_x_value);
                    mismatch_total++;
                end else begin
                    due = answers_due.pop_front();
                    if (m_status !== due.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, due.status, m_status);
                        mismatch_total++;
                    end
                    if (m_x_value !== due.x) begin
                        $display("%0t: x_value mismatch, expected %h, actual %h",
                                 $time, due.x, m_x_value);
                        mismatch_total++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_search(s_kind, s_left_x, s_right_x, s_target, s_func_value, fresh);
                answers_due.push_back(fresh);
            end
        end
        outstanding <= answers_due.size();
        failures    <= mismatch_total;
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the bracketed root search testbench: clock, reset, register setup and
// a responder that answers evaluation requests, mostly from a random test curve.
// Depends on brs_pkg, bracketed_root_search and root_search_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import brs_pkg::*;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;
    localparam int   ITEM_TARGET  = 1750;
    localparam int   DRAIN_CYCLES = 120;
    localparam int   FRAC_BITS    = 16;

    typedef enum int {
        CURVE_LINEAR,
        CURVE_STEP,
        CURVE_NOISE
    } curve_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_kind;
    logic [DATA_WIDTH-1:0]      s_left_x;
    logic [DATA_WIDTH-1:0]      s_right_x;
    logic [DATA_WIDTH-1:0]      s_target;
    logic [DATA_WIDTH-1:0]      s_func_value;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [STATUS_WIDTH-1:0]    m_status;
    logic [DATA_WIDTH-1:0]      m_x_value;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    int                         failures;
    int                         outstanding;

    logic [STATUS_WIDTH-1:0]    last_status = STATUS_IGNORED;
    logic [DATA_WIDTH-1:0]      last_x = '0;
    logic [11:0]                stall_clock = '0;

    int                         burst_left;
    bit                         steady;
    int                         items_sent;
    curve_t                     fn_shape;
    longint                     fn_slope, fn_offset, fn_knee;

    bracketed_root_search i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_left_x     (s_left_x),
        .s_right_x    (s_right_x),
        .s_target     (s_target),
        .s_func_value (s_func_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_x_value    (m_x_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    root_search_checker #(
        .START_KIND (KIND_START)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_left_x     (s_left_x),
        .s_right_x    (s_right_x),
        .s_target     (s_target),
        .s_func_value (s_func_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_x_value    (m_x_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        stall_clock <= stall_clock + 1'b1;
        case (stall_clock[11:10])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ($urandom_range(0, 2) != 0);
            2'd2:    m_ready <= stall_clock[3];
            default: m_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            last_status <= m_status;
            last_x      <= m_x_value;
        end
    end

    function automatic logic [DATA_WIDTH-1:0] curve_at(logic [DATA_WIDTH-1:0] x);
        longint xs, y;
        xs = longint'($signed(x));
        case (fn_shape)
            CURVE_LINEAR: y = ((xs * fn_slope) >>> FRAC_BITS) + fn_offset;
            CURVE_STEP:   y = (xs >= fn_knee) ? fn_offset + fn_slope : fn_offset - fn_slope;
            default:      y = longint'($signed($urandom()));
        endcase
        return y[DATA_WIDTH-1:0];
    endfunction

    task automatic send_beat(input logic kind, input logic [DATA_WIDTH-1:0] lx, rx, tg, fv);
        int gap;
        if (!steady && burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_left_x     <= lx;
        s_right_x    <= rx;
        s_target     <= tg;
        s_func_value <= fv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic await_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic start_search(input logic [DATA_WIDTH-1:0] lx, rx, tg);
        send_beat(KIND_START, lx, rx, tg, $urandom());
        items_sent++;
        await_results();
    endtask

    task automatic give_value(input logic [DATA_WIDTH-1:0] fv);
        send_beat(KIND_REPLY, $urandom(), $urandom(), $urandom(), fv);
        items_sent++;
        await_results();
    endtask

    task automatic await_cfg();
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_settings(input logic secant, input logic [ITER_WIDTH-1:0] limit,
                                 input logic [TOL_WIDTH-1:0] tol);
        logic [CFG_DATA_WIDTH-1:0] junk;
        junk      = CFG_DATA_WIDTH'($urandom());
        cfg_valid <= 1'b1;
        cfg_index <= CFG_METHOD;
        cfg_data  <= {junk[CFG_DATA_WIDTH-1:1], secant};
        await_cfg();
        cfg_index <= CFG_MAX_ITER;
        cfg_data  <= {junk[CFG_DATA_WIDTH-1:ITER_WIDTH], limit};
        await_cfg();
        cfg_index <= CFG_TOLERANCE;
        cfg_data  <= tol;
        await_cfg();
        cfg_valid <= 1'b0;
    endtask

    // Starts and replies without waiting for results between them, which also hits a busy block.
    task automatic send_noise(input int count);
        repeat (count) begin
            if ($urandom_range(0, 1) == 0) begin
                send_beat(KIND_START, $urandom(), $urandom(), $urandom(), $urandom());
            end else begin
                send_beat(KIND_REPLY, $urandom(), $urandom(), $urandom(), $urandom());
            end
            items_sent++;
        end
        await_results();
    endtask

    task automatic random_search();
        logic [DATA_WIDTH-1:0] lx, rx, tg, span, fv;
        lx   = $urandom();
        span = ($urandom_range(0, 7) == 0) ? $urandom() : ($urandom() >> $urandom_range(8, 31));
        rx   = lx + span;
        case ($urandom_range(0, 9))
            0, 1:    fn_shape = CURVE_STEP;
            2:       fn_shape = CURVE_NOISE;
            default: fn_shape = CURVE_LINEAR;
        endcase
        fn_slope = longint'($urandom_range(1, 1 << 20));
        if ($urandom_range(0, 1) == 1) fn_slope = -fn_slope;
        fn_offset = longint'($signed($urandom()));
        fn_knee   = longint'($signed(lx + (span >> 1)));
        tg = ($urandom_range(0, 3) == 0) ? $urandom() : curve_at(lx + (span >> $urandom_range(1, 3)));
        if ($urandom_range(0, 19) == 0) begin
            fv = lx;
            lx = rx;
            rx = fv;
        end
        start_search(lx, rx, tg);
        while (last_status == STATUS_EVAL && $urandom_range(0, 39) != 0) begin
            case ($urandom_range(0, 19))
                0:       fv = tg;
                1:       fv = $urandom();
                default: fv = curve_at(last_x);
            endcase
            give_value(fv);
        end
    endtask

    initial begin
        int                    round;
        logic                  secant;
        logic [ITER_WIDTH-1:0] limit;
        logic [TOL_WIDTH-1:0]  tol;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = KIND_START;
        s_left_x     = '0;
        s_right_x    = '0;
        s_target     = '0;
        s_func_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_METHOD;
        cfg_data     = '0;
        burst_left   = 0;
        steady       = 1'b0;
        items_sent   = 0;
        fn_shape     = CURVE_LINEAR;
        fn_slope     = 1;
        fn_offset    = 0;
        fn_knee      = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reply to an idle block, then a reversed bracket at the range extremes.
        give_value(32'hFFFF_FFFF);
        start_search(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        give_value(32'h7FFF_FFFF);
        give_value(32'h0000_0000);
        // Exact zero at the probe, then a bracket already within tolerance.
        start_search(32'h0000_0000, 32'h0008_0000, 32'h0000_0005);
        give_value(32'h0000_0000);
        give_value(32'h0000_0005);
        start_search(32'd100, 32'd101, 32'd0);
        give_value(32'hFFFF_FFFF);
        give_value(32'h0000_0001);
        // Zero residual at the left end, then a restart in the middle of a search.
        start_search(32'hFFFF_0000, 32'h0001_0000, 32'd7);
        give_value(32'd7);
        give_value(32'd3);
        start_search(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        give_value(32'h8000_0000);
        load_settings(1'b0, 6'd1, 16'd1);
        give_value(32'd1);
        // False position: equal end residuals and saturation at both ends.
        load_settings(1'b1, 6'd63, 16'd0);
        start_search(32'hFFFC_0000, 32'h0004_0000, 32'd0);
        give_value(32'd10);
        give_value(32'd10);
        start_search(32'h7FFF_0000, 32'h7FFF_FFFF, 32'd0);
        give_value(32'h8000_0000);
        give_value(32'h8000_0001);
        start_search(32'h8000_0000, 32'h8000_FFFF, 32'd0);
        give_value(32'h7FFF_FFFE);
        give_value(32'h7FFF_FFFF);

        round = 0;
        while (items_sent < ITEM_TARGET) begin
            case (round)
                0: begin secant = 1'b0; limit = 6'd63; tol = 16'd0;      end
                1: begin secant = 1'b1; limit = 6'd63; tol = 16'd0;      end
                2: begin secant = 1'b0; limit = 6'd0;  tol = 16'hFFFF;   end
                3: begin secant = 1'b1; limit = 6'd1;  tol = 16'hFFFF;   end
                default: begin
                    secant = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 5))
                        0:       limit = 6'd0;
                        1:       limit = 6'd1;
                        2:       limit = 6'd63;
                        default: limit = ITER_WIDTH'($urandom_range(1, 63));
                    endcase
                    case ($urandom_range(0, 5))
                        0:       tol = 16'd0;
                        1:       tol = 16'hFFFF;
                        2:       tol = 16'd1;
                        default: tol = TOL_WIDTH'($urandom_range(0, 1 << $urandom_range(0, 15)));
                    endcase
                end
            endcase
            load_settings(secant, limit, tol);
            steady = ($urandom_range(0, 3) == 0);
            repeat (8) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_noise($urandom_range(1, 6));
                end else begin
                    random_search();
                end
            end
            round++;
        end

        await_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #12ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
